// File: hdl/sofsw_pkg.sv
// Package for the symbol order block: sequencer states and status codes.
// No dependencies.
`timescale 1ns / 1ps
package sofsw_pkg;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PREFIX = 2'd1,
        ST_CYCLE  = 2'd2,
        ST_LONG   = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_POP   = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_CLEAR = 7'b1000000
    } t_state;

endpackage

// File: hdl/symbol_order_from_sorted_words.sv
// Top level of the symbol order block: word loader, topological sort sequencer.
// Depends on sofsw_pkg.
`timescale 1ns / 1ps
// Usage:
//   Raise start with a request while busy is low. Each request
//   holds one symbol (or none) and word/list end flags. The previous word is kept in a
//   memory with a registered read, so the compare of a character holds busy through
//   the cycle after its request.
//   The request with i_list_end starts the sort: a scan over all symbols finds
//   present symbols of zero in-degree, then each dequeued symbol walks its edge
//   row one column per cycle through one shared in-degree decrement unit.
//   Results then leave one per cycle on o_valid with no backpressure, the final
//   one flagged o_last. A clearing sweep over all symbols then empties edge rows
//   and in-degrees before busy drops.
//   Reset (i_rst_n low, synchronous) starts the same clearing sweep; the block
//   accepts no request until it finishes.
module symbol_order_from_sorted_words #(
    parameter int SYMBOLS      = 32,
    parameter int MAX_WORD_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] i_symbol,
    input  logic       i_carries_symbol,
    input  logic       i_word_end,
    input  logic       i_list_end,
    output logic       o_valid,
    output logic [4:0] o_order_symbol,
    output logic       o_symbol_valid,
    output logic       o_last,
    output sofsw_pkg::t_status o_status
);
    import sofsw_pkg::*;

    localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int CW = $clog2(SYMBOLS + 1);
    localparam int PW = $clog2(MAX_WORD_LEN + 1);
    localparam int AW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    t_state r_state, n_state;

    logic [SYMBOLS-1:0] r_edges [SYMBOLS];
    logic [SW-1:0]      r_indeg [SYMBOLS];
    logic [SW-1:0]      r_queue [SYMBOLS];
    logic [4:0]         r_prev  [MAX_WORD_LEN];
    logic [SYMBOLS-1:0] r_present;
    logic [PW-1:0]      r_prev_len, r_pos;
    logic               r_diff, r_have_prev;
    t_status            r_err;

    // pending character compare, registered from a character request
    logic               r_cmp;
    logic [SW-1:0]      r_cmp_sym;
    logic               r_cmp_close, r_cmp_lend;
    logic               r_cmp_long;
    logic [4:0]         r_rd;

    logic [SW-1:0]      r_idx, r_cur;
    logic [CW-1:0]      r_head, r_tail, r_count;

    logic accept;
    logic in_ok;
    logic [SW-1:0] in_sym;

    assign busy   = (r_state != S_LOAD) || r_cmp;
    assign accept = start && !busy;
    assign in_sym = SW'(i_symbol);
    assign in_ok  = i_carries_symbol && (32'(i_symbol) < SYMBOLS);

    // previous word memory, registered read
    always_ff @(posedge i_clk) begin
        if (accept && in_ok) begin
            r_rd <= r_prev[r_pos[AW-1:0]];
        end
        if (accept && in_ok && (32'(r_pos) < MAX_WORD_LEN)) begin
            r_prev[r_pos[AW-1:0]] <= i_symbol;
        end
    end

    // close-word update shared by both paths
    logic          cl_do;
    logic [PW-1:0] cl_pos;
    logic          cl_diff;

    // compare stage results; a character past the word limit compares nothing
    logic cmp_edge;
    assign cmp_edge = r_cmp && !r_cmp_long && r_have_prev && !r_diff
                      && (r_pos - PW'(1) < r_prev_len) && (SW'(r_rd) != r_cmp_sym);

    logic [SW-1:0] walk_col;
    assign walk_col = r_idx;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (r_cmp ? r_cmp_lend : (accept && i_list_end && !in_ok))
                         n_state = S_SCAN;
            S_SCAN:  if (32'(r_idx) == SYMBOLS - 1) n_state = S_POP;
            S_POP:   n_state = (r_head < r_tail) ? S_WALK : S_CHECK;
            S_WALK:  if (32'(r_idx) == SYMBOLS - 1) n_state = S_POP;
            S_CHECK: n_state = S_EMIT;
            S_EMIT:  if (o_last || r_err != ST_OK || r_count == '0 || r_tail != r_count)
                         n_state = S_CLEAR;
            S_CLEAR: if (32'(r_idx) == SYMBOLS - 1) n_state = S_LOAD;
            default: n_state = S_CLEAR;
        endcase
    end

    // result outputs
    always_comb begin
        o_valid        = (r_state == S_EMIT);
        o_symbol_valid = 1'b0;
        o_order_symbol = '0;
        o_last         = 1'b1;
        o_status       = r_err;
        if (r_err == ST_OK && r_count != '0) begin
            if (r_tail != r_count) begin
                o_status = ST_CYCLE;
            end else begin
                o_symbol_valid = 1'b1;
                o_order_symbol = 5'(r_queue[r_head[SW-1:0]]);
                o_last         = (r_head == r_tail - CW'(1));
            end
        end
    end

    always_comb begin
        cl_do   = r_cmp ? r_cmp_close : (accept && !in_ok && (i_word_end || i_list_end));
        cl_pos  = r_pos;
        cl_diff = r_diff || cmp_edge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_cmp       <= 1'b0;
            r_present   <= '0;
            r_prev_len  <= '0;
            r_pos       <= '0;
            r_diff      <= 1'b0;
            r_have_prev <= 1'b0;
            r_err       <= ST_OK;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_LOAD: begin
                    // take a character: mark it, queue compare
                    if (accept && in_ok) begin
                        r_present[in_sym] <= 1'b1;
                        r_cmp_sym   <= in_sym;
                        r_cmp_close <= i_word_end || i_list_end;
                        r_cmp_lend  <= i_list_end;
                        r_cmp       <= 1'b1;
                        r_cmp_long  <= (32'(r_pos) >= MAX_WORD_LEN);
                        if (32'(r_pos) >= MAX_WORD_LEN) begin
                            if (r_err == ST_OK) r_err <= ST_LONG;
                        end else begin
                            r_pos <= r_pos + PW'(1);
                        end
                    end else begin
                        r_cmp <= 1'b0;
                    end
                    // compare against previous word, add edge
                    if (r_cmp && cmp_edge && 32'(r_pos) <= MAX_WORD_LEN) begin
                        if (!r_edges[SW'(r_rd)][r_cmp_sym]) begin
                            r_edges[SW'(r_rd)][r_cmp_sym] <= 1'b1;
                            r_indeg[r_cmp_sym] <= r_indeg[r_cmp_sym] + SW'(1);
                        end
                    end
                    if (r_cmp && !cl_do) r_diff <= cl_diff;
                    // close the word
                    if (cl_do) begin
                        if (r_have_prev && !cl_diff && r_prev_len > cl_pos && r_err == ST_OK)
                            r_err <= ST_PREFIX;
                        r_prev_len  <= cl_pos;
                        r_have_prev <= 1'b1;
                        r_diff      <= 1'b0;
                        r_pos       <= '0;
                    end
                    r_idx <= '0;
                end
                S_SCAN: begin
                    // queue present roots, count present symbols
                    if (r_present[r_idx]) begin
                        r_count <= r_count + CW'(1);
                        if (r_indeg[r_idx] == '0) begin
                            r_queue[r_tail[SW-1:0]] <= r_idx;
                            r_tail <= r_tail + CW'(1);
                        end
                    end
                    r_idx <= r_idx + SW'(1);
                end
                S_POP: begin
                    r_cur  <= r_queue[r_head[SW-1:0]];
                    r_head <= r_head + CW'(1);
                    r_idx  <= '0;
                end
                S_WALK: begin
                    // release one successor per cycle
                    if (r_edges[r_cur][walk_col]) begin
                        r_indeg[walk_col] <= r_indeg[walk_col] - SW'(1);
                        if (r_indeg[walk_col] == SW'(1) && 32'(r_tail) < SYMBOLS) begin
                            r_queue[r_tail[SW-1:0]] <= walk_col;
                            r_tail <= r_tail + CW'(1);
                        end
                    end
                    r_idx <= r_idx + SW'(1);
                end
                S_CHECK: r_head <= '0;
                S_EMIT: begin
                    r_head <= r_head + CW'(1);
                    r_idx  <= '0;
                end
                S_CLEAR: begin
                    // sweep edge rows and in-degrees, drop list state
                    r_edges[r_idx] <= '0;
                    r_indeg[r_idx] <= '0;
                    r_idx       <= r_idx + SW'(1);
                    r_cmp       <= 1'b0;
                    r_present   <= '0;
                    r_prev_len  <= '0;
                    r_pos       <= '0;
                    r_diff      <= 1'b0;
                    r_have_prev <= 1'b0;
                    r_err       <= ST_OK;
                    r_head      <= '0;
                    r_tail      <= '0;
                    r_count     <= '0;
                end
                default: ;
            endcase
        end
    end

    // queue never overruns the present count
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_tail <= r_count)) else $error("queue overrun");
    // a valid result only leaves while busy, in the emit state
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    // compare stage never overlaps a new request
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp |-> !accept) else $error("request during compare");
endmodule

// File: sim/symbol_order_from_sorted_words_tb.sv
// Testbench for symbol_order_from_sorted_words: sorted word lists in, symbol order out.
// The scoreboard class predicts the order and checks each strobed result; tasks drive requests.
// Depends on sofsw_pkg and the block.
`timescale 1ns / 1ps

typedef struct {
    logic [4:0]         sym;
    logic               valid;
    logic               last;
    sofsw_pkg::t_status status;
} t_order_item;

class order_scoreboard;
    t_order_item        pending[$];
    int                 mismatches;
    bit [31:0]          seen_mask;
    bit [31:0]          edge_rows[32];
    int                 indeg[32];
    bit [4:0]           prev_word[64];
    int                 prev_len;
    int                 pos;
    bit                 differs;
    bit                 have_prev;
    sofsw_pkg::t_status first_err;

    function new();
        mismatches = 0;
        clear_list();
    endfunction

    function void clear_list();
        seen_mask = '0;
        for (int i = 0; i < 32; i++) begin
            edge_rows[i] = '0;
            indeg[i] = 0;
        end
        prev_len = 0;
        pos = 0;
        differs = 0;
        have_prev = 0;
        first_err = sofsw_pkg::ST_OK;
    endfunction

    function void flag_error(sofsw_pkg::t_status code);
        if (first_err == sofsw_pkg::ST_OK) first_err = code;
    endfunction

    function void push_result(logic [4:0] s, logic v, logic l, sofsw_pkg::t_status st);
        t_order_item r;
        r.sym = s;
        r.valid = v;
        r.last = l;
        r.status = st;
        pending.push_back(r);
    endfunction

    // Compute the sort at list end: Kahn order, FIFO queue seeded in ascending symbol order
    function void sort_symbols();
        bit [4:0] order[32];
        int head;
        int tail;
        int count;
        int cur;
        head = 0;
        tail = 0;
        count = 0;
        if (first_err != sofsw_pkg::ST_OK) begin
            push_result(5'd0, 1'b0, 1'b1, first_err);
            return;
        end
        for (int s = 0; s < 32; s++) begin
            if (seen_mask[s]) begin
                count++;
                if (indeg[s] == 0) order[tail++] = s[4:0];
            end
        end
        if (count == 0) begin
            push_result(5'd0, 1'b0, 1'b1, sofsw_pkg::ST_OK);
            return;
        end
        while (head < tail) begin
            cur = order[head++];
            for (int c = 0; c < 32; c++) begin
                if (edge_rows[cur][c]) begin
                    indeg[c]--;
                    if (indeg[c] == 0 && tail < 32) order[tail++] = c[4:0];
                end
            end
        end
        if (tail != count) begin
            push_result(5'd0, 1'b0, 1'b1, sofsw_pkg::ST_CYCLE);
            return;
        end
        for (int s = 0; s < tail; s++)
            push_result(order[s], 1'b1, (s + 1 == tail), sofsw_pkg::ST_OK);
    endfunction

    // Note one accepted request and update the predicted state
    function void note_request(logic [4:0] sym, logic carries, logic wend, logic lend);
        int p;
        if (carries) begin
            seen_mask[sym] = 1'b1;
            if (pos >= 64) begin
                flag_error(sofsw_pkg::ST_LONG);
            end else begin
                if (have_prev && !differs && pos < prev_len) begin
                    p = prev_word[pos];
                    if (p != sym) begin
                        if (!edge_rows[p][sym]) begin
                            edge_rows[p][sym] = 1'b1;
                            indeg[sym]++;
                        end
                        differs = 1;
                    end
                end
                prev_word[pos] = sym;
                pos++;
            end
        end
        if (wend || lend) begin
            if (have_prev && !differs && prev_len > pos) flag_error(sofsw_pkg::ST_PREFIX);
            prev_len = pos;
            have_prev = 1;
            differs = 0;
            pos = 0;
        end
        if (lend) begin
            sort_symbols();
            clear_list();
        end
    endfunction

    // Compare one strobed result with the oldest prediction
    function void check_result(logic [4:0] sym, logic v, logic l, sofsw_pkg::t_status st);
        t_order_item e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: sym=%0d valid=%0d last=%0d status=%0d",
                         sym, v, l, st);
            return;
        end
        e = pending.pop_front();
        if (e.sym !== sym || e.valid !== v || e.last !== l || e.status !== st) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp sym=%0d valid=%0d last=%0d status=%0d",
                         e.sym, e.valid, e.last, e.status);
                $display("          got sym=%0d valid=%0d last=%0d status=%0d",
                         sym, v, l, st);
            end
        end
    endfunction
endclass

module symbol_order_from_sorted_words_tb;
    import sofsw_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [4:0] i_symbol;
    logic       i_carries_symbol;
    logic       i_word_end;
    logic       i_list_end;
    logic       o_valid;
    logic [4:0] o_order_symbol;
    logic       o_symbol_valid;
    logic       o_last;
    t_status    o_status;

    order_scoreboard sb;
    int          idle_pct;
    int          sent_count;
    int          cycle_count;
    int          word_buf[8][70];
    int          word_len[8];
    int          sym_rank[32];

    symbol_order_from_sorted_words u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_symbol         (i_symbol),
        .i_carries_symbol (i_carries_symbol),
        .i_word_end       (i_word_end),
        .i_list_end       (i_list_end),
        .o_valid          (o_valid),
        .o_order_symbol   (o_order_symbol),
        .o_symbol_valid   (o_symbol_valid),
        .o_last           (o_last),
        .o_status         (o_status)
    );

    // Generate the 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Note accepted requests and check strobed results
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_request(i_symbol, i_carries_symbol, i_word_end, i_list_end);
        if (i_rst_n && o_valid)
            sb.check_result(o_order_symbol, o_symbol_valid, o_last, o_status);
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one request, with an optional random idle gap ahead of it
    task automatic send_req(input int sym, input bit c, input bit we, input bit le);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_symbol <= sym[4:0];
        i_carries_symbol <= c;
        i_word_end <= we;
        i_list_end <= le;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_count++;
    endtask

    // Drop start once the stream pauses
    task automatic go_quiet();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    // Send a word given as a list of symbols
    task automatic send_word(input int len, input int idx, input bit closes_list);
        for (int i = 0; i < len; i++)
            send_req(word_buf[idx][i], 1'b1, i == len - 1, closes_list && i == len - 1);
    endtask

    // Return 1 when word a sorts after word b under the current rank
    function automatic bit word_after(input int a, input int b);
        int n;
        n = (word_len[a] < word_len[b]) ? word_len[a] : word_len[b];
        for (int i = 0; i < n; i++) begin
            if (word_buf[a][i] != word_buf[b][i])
                return sym_rank[word_buf[a][i]] > sym_rank[word_buf[b][i]];
        end
        return word_len[a] > word_len[b];
    endfunction

    // Build one random list, mostly well formed, and send it
    task automatic send_random_list();
        int nw;
        int k;
        int alpha[8];
        int tmp;
        bit sorted;
        bit long_word;
        nw = $urandom_range(1, 7);
        k = $urandom_range(2, 8);
        sorted = ($urandom_range(99) < 75);
        long_word = ($urandom_range(99) < 3);
        for (int i = 0; i < 32; i++) sym_rank[i] = $urandom;
        for (int i = 0; i < k; i++) alpha[i] = $urandom_range(31);
        for (int w = 0; w < nw; w++) begin
            word_len[w] = (long_word && w == 0) ? $urandom_range(64, 67) : $urandom_range(1, 5);
            for (int i = 0; i < word_len[w]; i++)
                word_buf[w][i] = alpha[$urandom_range(k - 1)];
        end
        // Sort words by the hidden alphabet
        if (sorted) begin
            for (int a = 0; a < nw; a++) begin
                for (int b = 0; b < nw - 1 - a; b++) begin
                    if (word_after(b, b + 1)) begin
                        for (int i = 0; i < 70; i++) begin
                            tmp = word_buf[b][i];
                            word_buf[b][i] = word_buf[b + 1][i];
                            word_buf[b + 1][i] = tmp;
                        end
                        tmp = word_len[b];
                        word_len[b] = word_len[b + 1];
                        word_len[b + 1] = tmp;
                    end
                end
            end
        end
        for (int w = 0; w < nw; w++) begin
            // Insert noise: idle items and empty words
            if ($urandom_range(99) < 8) send_req($urandom_range(31), 1'b0, 1'b0, 1'b0);
            if ($urandom_range(99) < 5) send_req($urandom_range(31), 1'b0, 1'b1, 1'b0);
            if (w == nw - 1 && $urandom_range(99) < 20) begin
                for (int i = 0; i < word_len[w]; i++)
                    send_req(word_buf[w][i], 1'b1, 1'b0, 1'b0);
                send_req($urandom_range(31), 1'b0, $urandom_range(1), 1'b1);
            end else begin
                send_word(word_len[w], w, w == nw - 1);
            end
        end
    endtask

    // Send a fixed two-word list, each word a run of consecutive symbol codes from its start
    task automatic send_fixed(input int len0, input int s0, input int len1, input int s1);
        word_len[0] = len0;
        word_len[1] = len1;
        for (int i = 0; i < len0; i++) word_buf[0][i] = s0 + i;
        for (int i = 0; i < len1; i++) word_buf[1][i] = s1 + i;
        send_word(len0, 0, 1'b0);
        send_word(len1, 1, 1'b1);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        int phase_pct[4];
        sb = new();
        phase_pct[0] = 0;
        phase_pct[1] = 51;
        phase_pct[2] = 0;
        phase_pct[3] = 33;
        idle_pct = 0;
        sent_count = 0;
        cycle_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_symbol = '0;
        i_carries_symbol = 1'b0;
        i_word_end = 1'b0;
        i_list_end = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes: symbols 0 and 31 in order
        send_req(0, 1'b1, 1'b1, 1'b0);
        send_req(31, 1'b1, 1'b1, 1'b1);
        // Empty list: no symbol seen
        send_req(7, 1'b0, 1'b0, 1'b1);
        // Prefix order error: longer word before its prefix
        send_fixed(2, 3, 1, 3);
        // Cycle: a < b then b < a
        send_req(1, 1'b1, 1'b1, 1'b0);
        send_req(2, 1'b1, 1'b1, 1'b0);
        send_req(1, 1'b1, 1'b1, 1'b1);
        // List end without word end, plus an idle item
        send_req(9, 1'b1, 1'b0, 1'b0);
        send_req(4, 1'b0, 1'b0, 1'b0);
        send_req(5, 1'b1, 1'b0, 1'b1);
        // Two error lists: a prefix error, then a word too long
        send_fixed(2, 10, 1, 10);
        go_quiet();
        wait_drained();
        word_len[0] = 66;
        for (int i = 0; i < 66; i++) word_buf[0][i] = (i * 7) % 32;
        send_word(66, 0, 1'b1);

        // Random lists over the idle phases
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = phase_pct[ph];
            while (sent_count < 100 * (ph + 1) + 70) send_random_list();
        end
        go_quiet();
        wait_drained();

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
